// ===== rtl/ors_pkg.sv =====
// Shared types and constants for the one-wire ROM search decision engine.
// Used by every module of the block; has no dependencies of its own.

package ors_pkg;

	// Width of the ROM code being searched, in bits.
	localparam int ROM_BITS = 64;
	// Bit position counter holds 1 to ROM_BITS.
	localparam int POS_W = $clog2(ROM_BITS + 1);
	localparam int BIT_IDX_W = $clog2(ROM_BITS);
	// Family discrepancy only tracks positions below this limit.
	localparam int FAMILY_LIMIT = 9;
	localparam int FAM_W = 4;
	localparam int ROM_OUT_W = 64;

	localparam logic [7:0] CMD_NORMAL = 8'hF0;
	localparam logic [7:0] CMD_ALARM = 8'hEC;

	typedef enum logic [1:0] {
		OP_BEGIN = 2'd0,
		OP_BIT = 2'd1,
		OP_RESET = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		K_CMD = 3'd0,
		K_WRITE = 3'd1,
		K_NOPRES = 3'd2,
		K_NOMORE = 3'd3,
		K_NORESP = 3'd4,
		K_IGNORED = 3'd5
	} kind_t;

	typedef struct packed {
		opcode_t opcode;
		logic presence;
		logic id_bit;
		logic complement_bit;
	} item_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] command_byte;
		logic direction;
		logic pass_done;
		logic found;
		logic last_device;
		logic [ROM_OUT_W-1:0] rom_address;
		logic [FAM_W-1:0] family_discrepancy;
	} result_t;

	typedef struct packed {
		logic pass_active;
		logic [POS_W-1:0] bit_position;
	} status_t;

endpackage

// ===== rtl/ors_in_stage.sv =====
// Input register of the ROM search engine: holds one item until the core takes it.
// Depends on ors_pkg for the item type.

module ors_in_stage import ors_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input item_t in_item,
	output logic valid_s1,
	output item_t item_s1,
	input logic advance
);

	// The stage can load when empty or when its item moves on this cycle.
	assign in_ready = !valid_s1 || advance;

	// Valid flag of the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of the input stage; needs no reset.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== rtl/ors_core.sv =====
// Search state and per-item decision logic of the ROM search engine.
// Depends on ors_pkg for item, result and status types and the command bytes.

module ors_core import ors_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic conditional_search,
	input item_t item,
	input logic fire,
	output result_t result,
	output status_t status
);

	logic [ROM_BITS-1:0] rom_q, rom_n;
	logic [POS_W-1:0] last_disc_q, last_disc_n;
	logic last_dev_q, last_dev_n;
	logic [FAM_W-1:0] fam_q, fam_n;
	logic [POS_W-1:0] bit_pos_q, bit_pos_n;
	logic [POS_W-1:0] zero_pos_q, zero_pos_n;
	logic pass_q, pass_n;

	logic [BIT_IDX_W-1:0] bit_idx;
	logic dir;
	logic is_done;

	assign bit_idx = BIT_IDX_W'(bit_pos_q - POS_W'(1));
	assign is_done = (bit_pos_q >= POS_W'(ROM_BITS));

	// Direction choice: a differing pair dictates the bit, a discrepancy
	// follows the previous pass below the last discrepancy, takes one at it and zero above it.
	always_comb begin
		if (item.id_bit != item.complement_bit) begin
			dir = item.id_bit;
		end else if (bit_pos_q < last_disc_q) begin
			dir = rom_q[bit_idx];
		end else begin
			dir = (bit_pos_q == last_disc_q);
		end
	end

	// Next state and result for the item at the head of the input stage.
	always_comb begin
		rom_n = rom_q;
		last_disc_n = last_disc_q;
		last_dev_n = last_dev_q;
		fam_n = fam_q;
		bit_pos_n = bit_pos_q;
		zero_pos_n = zero_pos_q;
		pass_n = pass_q;
		result = '0;
		result.kind = K_IGNORED;

		unique case (item.opcode)
			OP_BEGIN: begin
				pass_n = 1'b0;
				bit_pos_n = POS_W'(1);
				zero_pos_n = '0;
				if (last_dev_q) begin
					last_disc_n = '0;
					last_dev_n = 1'b0;
					fam_n = '0;
					result.kind = K_NOMORE;
				end else if (!item.presence) begin
					last_disc_n = '0;
					last_dev_n = 1'b0;
					fam_n = '0;
					result.kind = K_NOPRES;
				end else begin
					pass_n = 1'b1;
					result.kind = K_CMD;
					result.command_byte = conditional_search ? CMD_ALARM : CMD_NORMAL;
				end
			end
			OP_RESET: begin
				rom_n = '0;
				last_disc_n = '0;
				last_dev_n = 1'b0;
				fam_n = '0;
				pass_n = 1'b0;
				bit_pos_n = POS_W'(1);
				zero_pos_n = '0;
			end
			OP_BIT: begin
				if (pass_q) begin
					if (item.id_bit && item.complement_bit) begin
						// No device answered the slot: the pass is abandoned.
						last_disc_n = '0;
						last_dev_n = 1'b0;
						fam_n = '0;
						pass_n = 1'b0;
						bit_pos_n = POS_W'(1);
						zero_pos_n = '0;
						result.kind = K_NORESP;
					end else begin
						if ((item.id_bit == item.complement_bit) && !dir) begin
							zero_pos_n = bit_pos_q;
							if (bit_pos_q < POS_W'(FAMILY_LIMIT)) begin
								fam_n = bit_pos_q[FAM_W-1:0];
							end
						end
						rom_n[bit_idx] = dir;
						result.kind = K_WRITE;
						result.direction = dir;
						if (is_done) begin
							// End of the pass: record where the next pass turns.
							result.pass_done = 1'b1;
							last_disc_n = zero_pos_n;
							last_dev_n = last_dev_q || (zero_pos_n == '0);
							if (rom_n[7:0] == 8'h00) begin
								last_disc_n = '0;
								last_dev_n = 1'b0;
								fam_n = '0;
							end else begin
								result.found = 1'b1;
								result.last_device = last_dev_n;
								result.rom_address = ROM_OUT_W'(rom_n);
							end
							pass_n = 1'b0;
							bit_pos_n = POS_W'(1);
							zero_pos_n = '0;
						end else begin
							bit_pos_n = bit_pos_q + POS_W'(1);
						end
						result.family_discrepancy = fam_n;
					end
				end
			end
			default: begin
				result.kind = K_IGNORED;
			end
		endcase
	end

	// Search state registers, updated when an item leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_q <= '0;
			last_disc_q <= '0;
			last_dev_q <= 1'b0;
			fam_q <= '0;
			bit_pos_q <= POS_W'(1);
			zero_pos_q <= '0;
			pass_q <= 1'b0;
		end else if (fire) begin
			rom_q <= rom_n;
			last_disc_q <= last_disc_n;
			last_dev_q <= last_dev_n;
			fam_q <= fam_n;
			bit_pos_q <= bit_pos_n;
			zero_pos_q <= zero_pos_n;
			pass_q <= pass_n;
		end
	end

	assign status.pass_active = pass_q;
	assign status.bit_position = bit_pos_q;

endmodule

// ===== rtl/ors_out_stage.sv =====
// Result register of the ROM search engine, holding one item for the output side.
// Depends on ors_pkg for the result type.

module ors_out_stage import ors_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic valid_s1,
	input result_t result,
	output logic advance,
	output logic out_valid,
	input logic out_ready,
	output result_t out_result
);

	// The register takes a new item when empty or when its item is taken.
	assign advance = !out_valid || out_ready;

	// Valid flag of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	// Result payload; needs no reset.
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_result <= result;
		end
	end

endmodule

// ===== rtl/onewire_rom_search_unit.sv =====
// Top level of the one-wire ROM search decision engine.
// An accepted item enters the input register and its result the result register.
// Throughput: one item per cycle unless m_tready stalls; set by the single step
// of search state update between the input register and the result register.
// Reset (arst_n low, asynchronous): search state, ROM register and the
// conditional search register clear, the bit position returns to one.

module onewire_rom_search_unit import ors_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata,    // [0] presence, [1] id_bit, [2] complement_bit, rest zero
	input logic [1:0] s_tuser,    // [1:0] opcode
	output logic m_tvalid,
	input logic m_tready,
	output logic [79:0] m_tdata,  // [7:0] command_byte, [8] direction, [9] pass_done,
	                              // [10] found, [11] last_device, [75:12] rom_address,
	                              // [79:76] family_discrepancy
	output logic [2:0] m_tuser,   // [2:0] kind
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_data
);

	item_t in_item;
	item_t item_s1;
	logic valid_s1;
	logic advance;
	logic fire;
	logic cond_q;
	result_t result;
	result_t out_result;
	status_t status;

	// Unpack the input item.
	assign in_item.opcode = opcode_t'(s_tuser);
	assign in_item.presence = s_tdata[0];
	assign in_item.id_bit = s_tdata[1];
	assign in_item.complement_bit = s_tdata[2];

	// Conditional search register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cond_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			cond_q <= cfg_data;
		end
	end

	ors_in_stage u_in (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_item(in_item),
		.valid_s1(valid_s1),
		.item_s1(item_s1),
		.advance(advance)
	);

	assign fire = valid_s1 && advance;

	ors_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.conditional_search(cond_q),
		.item(item_s1),
		.fire(fire),
		.result(result),
		.status(status)
	);

	ors_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.valid_s1(valid_s1),
		.result(result),
		.advance(advance),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_result(out_result)
	);

	// Pack the result item.
	assign m_tuser = out_result.kind;
	assign m_tdata = {out_result.family_discrepancy, out_result.rom_address,
		out_result.last_device, out_result.found, out_result.pass_done,
		out_result.direction, out_result.command_byte};

	// A found device is only reported on the last write bit of a pass.
	a_found_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[10] |-> m_tdata[9] && (m_tuser == K_WRITE))
		else $error("found reported outside the end of a pass");

	// Outside a pass the bit position waits at the first bit.
	a_idle_position: assert property (@(posedge clk) disable iff (!arst_n)
		!status.pass_active |-> (status.bit_position == POS_W'(1)))
		else $error("bit position not rewound while no pass is active");

	// An empty result register never holds back the input side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty result register");

endmodule
